// ===== hdl/tsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_pkg
// shared types and constants of the wrap-addressed bilinear texture sampler
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int DEF_MAX_WIDTH       = 256;
    localparam int DEF_MAX_HEIGHT      = 256;
    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH         = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_REG_W = 9;

    localparam logic REG_TEX_WIDTH  = 1'b0;
    localparam logic REG_TEX_HEIGHT = 1'b1;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;

    // item class handed from front to back
    typedef struct packed {
        logic is_sample;
        logic wr_en;
        logic bil;
    } tsw_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/tsw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_front
// accepts items, wraps coordinates and forms the texel addresses
// ----------------------------------------------------------------------------
module tsw_front
    import tsw_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int AW              = $clog2(MAX_WIDTH * MAX_HEIGHT)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [SIZE_REG_W-1:0] tex_width,
    input  wire logic [SIZE_REG_W-1:0] tex_height,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  mode,
    input  wire logic [15:0]           texel_address,
    input  wire logic [7:0]            red_in,
    input  wire logic [7:0]            green_in,
    input  wire logic [7:0]            blue_in,
    input  wire logic signed [23:0]    coord_u,
    input  wire logic signed [23:0]    coord_v,
    input  wire logic                  use_bilinear,
    input  wire logic                  q_full,
    output logic                       push,
    output tsw_ctl_t                   push_ctl,
    output logic [AW-1:0]              push_addr_a,
    output logic [AW-1:0]              push_addr_b,
    output logic [23:0]                push_texel,
    output logic [7:0]                 push_fx,
    output logic [7:0]                 push_fy
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int SW    = $clog2(MAX_WIDTH + 1);
    localparam int SH    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int MW    = YW + SW + 1;

    logic [SW-1:0] w_eff;
    logic [SH-1:0] h_eff;
    logic          fen;

    logic          f1_valid_reg;
    logic          f1_mode_reg;
    logic [15:0]   f1_addr_reg;
    logic [23:0]   f1_texel_reg;
    logic [F-1:0]  f1_u_reg;
    logic [F-1:0]  f1_v_reg;
    logic          f1_bil_reg;

    logic [SW+F-1:0] ru;
    logic [SH+F-1:0] rv;
    logic [XW-1:0]   x_next;
    logic [YW-1:0]   y_next;
    logic            bil_next;
    logic            wr_ok_next;

    logic          f2_valid_reg;
    logic          f2_mode_reg;
    logic          f2_wr_ok_reg;
    logic [15:0]   f2_addr_reg;
    logic [23:0]   f2_texel_reg;
    logic [XW-1:0] f2_x_reg;
    logic [YW-1:0] f2_y_reg;
    logic [7:0]    f2_fx_reg;
    logic [7:0]    f2_fy_reg;
    logic          f2_bil_reg;

    logic [MW-1:0] a_calc;
    logic [AW-1:0] a_next;
    logic [AW-1:0] b_next;
    tsw_ctl_t      ctl_next;

    logic          f3_valid_reg;
    tsw_ctl_t      f3_ctl_reg;
    logic [AW-1:0] f3_a_reg;
    logic [AW-1:0] f3_b_reg;
    logic [23:0]   f3_texel_reg;
    logic [7:0]    f3_fx_reg;
    logic [7:0]    f3_fy_reg;

    always_comb
    begin
        if (tex_width == '0)
        begin
            w_eff = SW'(1);
        end
        else if (32'(tex_width) > 32'(MAX_WIDTH))
        begin
            w_eff = SW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = SW'(tex_width);
        end
        if (tex_height == '0)
        begin
            h_eff = SH'(1);
        end
        else if (32'(tex_height) > 32'(MAX_HEIGHT))
        begin
            h_eff = SH'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = SH'(tex_height);
        end
    end

    assign fen      = !f3_valid_reg || !q_full;
    assign in_ready = fen;

    // stage 1: capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (fen)
        begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            f1_mode_reg  <= mode;
            f1_addr_reg  <= texel_address;
            f1_texel_reg <= {red_in, green_in, blue_in};
            f1_u_reg     <= coord_u[F-1:0];
            f1_v_reg     <= coord_v[F-1:0];
            f1_bil_reg   <= use_bilinear;
        end
    end

    // stage 2: scale and wrap, the wrapped product is size times the fraction
    always_comb
    begin
        ru         = (SW+F)'(w_eff) * (SW+F)'(f1_u_reg);
        rv         = (SH+F)'(h_eff) * (SH+F)'(f1_v_reg);
        x_next     = ru[F +: XW];
        y_next     = rv[F +: YW];
        bil_next   = f1_bil_reg && (32'(x_next) + 32'd2 < 32'(w_eff))
                                && (32'(y_next) + 32'd2 < 32'(h_eff));
        wr_ok_next = 32'(f1_addr_reg) < 32'(DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_valid_reg <= 1'b0;
        end
        else if (fen)
        begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            f2_mode_reg  <= f1_mode_reg;
            f2_wr_ok_reg <= wr_ok_next;
            f2_addr_reg  <= f1_addr_reg;
            f2_texel_reg <= f1_texel_reg;
            f2_x_reg     <= x_next;
            f2_y_reg     <= y_next;
            f2_fx_reg    <= ru[F-1 -: 8];
            f2_fy_reg    <= rv[F-1 -: 8];
            f2_bil_reg   <= bil_next;
        end
    end

    // stage 3: linear address
    always_comb
    begin
        a_calc = MW'(MW'(f2_y_reg) * MW'(w_eff)) + MW'(f2_x_reg);
        if (f2_mode_reg)
        begin
            a_next = AW'(a_calc);
        end
        else
        begin
            a_next = AW'(f2_addr_reg);
        end
        b_next             = AW'(a_calc) + AW'(w_eff);
        ctl_next.is_sample = f2_mode_reg;
        ctl_next.wr_en     = !f2_mode_reg && f2_wr_ok_reg;
        ctl_next.bil       = f2_bil_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f3_valid_reg <= 1'b0;
        end
        else if (fen)
        begin
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            f3_ctl_reg   <= ctl_next;
            f3_a_reg     <= a_next;
            f3_b_reg     <= b_next;
            f3_texel_reg <= f2_texel_reg;
            f3_fx_reg    <= f2_fx_reg;
            f3_fy_reg    <= f2_fy_reg;
        end
    end

    assign push        = fen && f3_valid_reg;
    assign push_ctl    = f3_ctl_reg;
    assign push_addr_a = f3_a_reg;
    assign push_addr_b = f3_b_reg;
    assign push_texel  = f3_texel_reg;
    assign push_fx     = f3_fx_reg;
    assign push_fy     = f3_fy_reg;

endmodule

`default_nettype wire

// ===== hdl/tsw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_queue
// short item queue between the front and the back
// ----------------------------------------------------------------------------
module tsw_queue
    import tsw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    tail_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[head_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !pop_valid))
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count lost a push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/tsw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsw_back
// banked texel store, neighbor fetch and bilinear blend
// ----------------------------------------------------------------------------
module tsw_back
    import tsw_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               pop,
    input  wire tsw_ctl_t      q_ctl,
    input  wire logic [AW-1:0] q_addr_a,
    input  wire logic [AW-1:0] q_addr_b,
    input  wire logic [23:0]   q_texel,
    input  wire logic [7:0]    q_fx,
    input  wire logic [7:0]    q_fy,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        red_out,
    output logic [15:0]        green_out,
    output logic [15:0]        blue_out
);

    localparam int BW         = AW - 1;
    localparam int BANK_DEPTH = 2 ** BW;

    function automatic logic [15:0] blend_row(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] f);
        logic [16:0] s;
        s = 17'(a) * 17'(9'd256 - 9'(f)) + 17'(b) * 17'(f);
        return s[15:0];
    endfunction

    function automatic logic [15:0] blend_col(input logic [15:0] a, input logic [15:0] b,
                                              input logic [7:0] f);
        logic [24:0] s;
        s = 25'(a) * 25'(9'd256 - 9'(f)) + 25'(b) * 25'(f);
        return s[23:8];
    endfunction

    logic [23:0] even_mem [BANK_DEPTH];
    logic [23:0] odd_mem  [BANK_DEPTH];

    logic        en;
    logic [AW:0] ap1;
    logic [AW:0] bp1;

    logic        s1_valid_reg;
    logic        s1_bil_reg;
    logic [7:0]  s1_fx_reg;
    logic [7:0]  s1_fy_reg;
    logic        s1_pa_reg;
    logic        s1_pb_reg;
    logic [23:0] e_top_reg;
    logic [23:0] o_top_reg;
    logic [23:0] e_bot_reg;
    logic [23:0] o_bot_reg;

    logic [23:0] t00;
    logic [23:0] t10;
    logic [23:0] t01;
    logic [23:0] t11;

    logic        s2_valid_reg;
    logic        s2_bil_reg;
    logic [7:0]  s2_fy_reg;
    logic [15:0] s2_top_reg  [3];
    logic [15:0] s2_bot_reg  [3];
    logic [7:0]  s2_near_reg [3];

    logic        out_valid_reg;
    logic [15:0] res_reg [3];

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && q_valid;
    assign ap1 = {1'b0, q_addr_a} + (AW+1)'(1);
    assign bp1 = {1'b0, q_addr_b} + (AW+1)'(1);

    // even bank holds even linear addresses
    always_ff @(posedge clk)
    begin
        if (pop && q_ctl.wr_en && !q_addr_a[0])
        begin
            even_mem[q_addr_a[AW-1:1]] <= q_texel;
        end
        if (en)
        begin
            e_top_reg <= even_mem[ap1[AW-1:1]];
            e_bot_reg <= even_mem[bp1[AW-1:1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_ctl.wr_en && q_addr_a[0])
        begin
            odd_mem[q_addr_a[AW-1:1]] <= q_texel;
        end
        if (en)
        begin
            o_top_reg <= odd_mem[q_addr_a[AW-1:1]];
            o_bot_reg <= odd_mem[q_addr_b[AW-1:1]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pop && q_ctl.is_sample;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_bil_reg <= q_ctl.bil;
            s1_fx_reg  <= q_fx;
            s1_fy_reg  <= q_fy;
            s1_pa_reg  <= q_addr_a[0];
            s1_pb_reg  <= q_addr_b[0];
        end
    end

    always_comb
    begin
        t00 = s1_pa_reg ? o_top_reg : e_top_reg;
        t10 = s1_pa_reg ? e_top_reg : o_top_reg;
        t01 = s1_pb_reg ? o_bot_reg : e_bot_reg;
        t11 = s1_pb_reg ? e_bot_reg : o_bot_reg;
    end

    // row blend, then column blend into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_bil_reg <= s1_bil_reg;
            s2_fy_reg  <= s1_fy_reg;
            for (int c = 0; c < 3; c++)
            begin
                s2_top_reg[c]  <= blend_row(t00[23-8*c -: 8], t10[23-8*c -: 8], s1_fx_reg);
                s2_bot_reg[c]  <= blend_row(t01[23-8*c -: 8], t11[23-8*c -: 8], s1_fx_reg);
                s2_near_reg[c] <= t00[23-8*c -: 8];
            end
            for (int c = 0; c < 3; c++)
            begin
                res_reg[c] <= s2_bil_reg ? blend_col(s2_top_reg[c], s2_bot_reg[c], s2_fy_reg)
                                         : {s2_near_reg[c], 8'h00};
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];

endmodule

`default_nettype wire

// ===== hdl/texture_sampler_wrap_bilinear.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear
// wrap-addressed RGB texture sampler with nearest or bilinear filtering
// ----------------------------------------------------------------------------
// Takes one item per clock while in_ready is high. A write item stores a texel;
// a sample item gives one result after three front stages (capture, coordinate
// scale and wrap, address multiply), the four-entry queue, then texel read, row
// blend and column blend. The texel store is split into even and odd banks by
// linear address, each read at two addresses a cycle, so all four bilinear
// neighbors come out in one read. Texels must be written before they are
// sampled; the store has no reset. The user must set width and height over the
// register port only while the block is idle; the block does not enforce it.
// Zero acts as one and values above the maximum act as the maximum.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_bilinear
    import tsw_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  mode,
    input  wire logic [15:0]           texel_address,
    input  wire logic [7:0]            red_in,
    input  wire logic [7:0]            green_in,
    input  wire logic [7:0]            blue_in,
    input  wire logic signed [23:0]    coord_u,
    input  wire logic signed [23:0]    coord_v,
    input  wire logic                  use_bilinear,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [15:0]                red_out,
    output logic [15:0]                green_out,
    output logic [15:0]                blue_out
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CTW = $bits(tsw_ctl_t);
    localparam int QW  = CTW + 2 * AW + 24 + 16;

    logic [SIZE_REG_W-1:0] tex_width_reg;
    logic [SIZE_REG_W-1:0] tex_height_reg;
    logic                  cfg_wr;

    logic          push;
    tsw_ctl_t      push_ctl;
    logic [AW-1:0] push_addr_a;
    logic [AW-1:0] push_addr_b;
    logic [23:0]   push_texel;
    logic [7:0]    push_fx;
    logic [7:0]    push_fy;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    logic [QW-1:0] q_data;
    tsw_ctl_t      q_ctl;
    logic [AW-1:0] q_addr_a;
    logic [AW-1:0] q_addr_b;
    logic [23:0]   q_texel;
    logic [7:0]    q_fx;
    logic [7:0]    q_fy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= SIZE_RESET;
            tex_height_reg <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TEX_WIDTH:  tex_width_reg  <= pwdata[SIZE_REG_W-1:0];
                REG_TEX_HEIGHT: tex_height_reg <= pwdata[SIZE_REG_W-1:0];
                default:        tex_width_reg  <= tex_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TEX_WIDTH:  prdata = CFG_DATA_W'(tex_width_reg);
            REG_TEX_HEIGHT: prdata = CFG_DATA_W'(tex_height_reg);
            default:        prdata = '0;
        endcase
    end

    tsw_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .AW              (AW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .tex_width     (tex_width_reg),
        .tex_height    (tex_height_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .texel_address (texel_address),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .coord_u       (coord_u),
        .coord_v       (coord_v),
        .use_bilinear  (use_bilinear),
        .q_full        (q_full),
        .push          (push),
        .push_ctl      (push_ctl),
        .push_addr_a   (push_addr_a),
        .push_addr_b   (push_addr_b),
        .push_texel    (push_texel),
        .push_fx       (push_fx),
        .push_fy       (push_fy)
    );

    tsw_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_addr_a, push_addr_b, push_texel, push_fx, push_fy}),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign {q_ctl, q_addr_a, q_addr_b, q_texel, q_fx, q_fy} = q_data;

    tsw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_ctl     (q_ctl),
        .q_addr_a  (q_addr_a),
        .q_addr_b  (q_addr_b),
        .q_texel   (q_texel),
        .q_fx      (q_fx),
        .q_fy      (q_fy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

`default_nettype wire
